@@ rtl/amvt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix vertex table package
// Shared constants, command and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package amvt_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int LABEL_W = 8;
  localparam int INDEX_W = 6;
  localparam int TOTAL_W = 7;

  localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_READ     = 2'd2;
  localparam logic [1:0] CMD_CLEAR    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_SCAN     = 4'd2;
  localparam logic [3:0] OP_ADD_A    = 4'd3;
  localparam logic [3:0] OP_ADD_B    = 4'd4;
  localparam logic [3:0] OP_RD_A     = 4'd5;
  localparam logic [3:0] OP_WR_A     = 4'd6;
  localparam logic [3:0] OP_RD_B     = 4'd7;
  localparam logic [3:0] OP_WR_B     = 4'd8;
  localparam logic [3:0] OP_DEL_INIT = 4'd9;
  localparam logic [3:0] OP_DEL      = 4'd10;
  localparam logic [3:0] OP_DEL_END  = 4'd11;
  localparam logic [3:0] OP_RD1      = 4'd12;
  localparam logic [3:0] OP_RD2      = 4'd13;
  localparam logic [3:0] OP_RD3      = 4'd14;
  localparam logic [3:0] OP_CLEAR    = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       res_set;
    logic [1:0] res_status;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic del_done;
    logic found_a;
    logic full;
    logic range_err;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/amvt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix vertex table controller
// Sequences lookup, insert, compaction, read and clear steps for one word at a time.
// ----------------------------------------------------------------------------
module amvt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    command,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire amvt_pkg::sts_t sts,
  output amvt_pkg::ctl_t     ctl
);
  import amvt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_ADD_A  = 4'd3;
  localparam logic [3:0] S_ADD_B  = 4'd4;
  localparam logic [3:0] S_RD_A   = 4'd5;
  localparam logic [3:0] S_WR_A   = 4'd6;
  localparam logic [3:0] S_RD_B   = 4'd7;
  localparam logic [3:0] S_WR_B   = 4'd8;
  localparam logic [3:0] S_DEL    = 4'd9;
  localparam logic [3:0] S_RD1    = 4'd10;
  localparam logic [3:0] S_RD2    = 4'd11;
  localparam logic [3:0] S_RD3    = 4'd12;
  localparam logic [3:0] S_CLR    = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0] state, state_next;
  logic [1:0] cmd, cmd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= CMD_ADD_EDGE;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    ctl = '{op: OP_NONE, res_set: 1'b0, res_status: ST_OK};
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.op = OP_LOAD;
          cmd_next = command;
          unique case (command)
            CMD_ADD_EDGE, CMD_DELETE: state_next = S_SCAN;
            CMD_READ: state_next = S_RD1;
            default: state_next = S_CLR;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end else begin
          ctl.op = OP_SCAN;
        end
      end
      S_DECIDE: begin
        if (cmd == CMD_ADD_EDGE) begin
          if (sts.full) begin
            ctl.res_set = 1'b1;
            ctl.res_status = ST_FULL;
            state_next = S_OUT;
          end else begin
            state_next = S_ADD_A;
          end
        end else if (!sts.found_a) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_NOT_FOUND;
          state_next = S_OUT;
        end else begin
          ctl.op = OP_DEL_INIT;
          state_next = S_DEL;
        end
      end
      S_ADD_A: begin
        ctl.op = OP_ADD_A;
        state_next = S_ADD_B;
      end
      S_ADD_B: begin
        ctl.op = OP_ADD_B;
        state_next = S_RD_A;
      end
      S_RD_A: begin
        ctl.op = OP_RD_A;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        ctl.op = OP_WR_A;
        state_next = S_RD_B;
      end
      S_RD_B: begin
        ctl.op = OP_RD_B;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        ctl.op = OP_WR_B;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        state_next = S_OUT;
      end
      S_DEL: begin
        if (sts.del_done) begin
          ctl.op = OP_DEL_END;
          ctl.res_set = 1'b1;
          ctl.res_status = ST_OK;
          state_next = S_OUT;
        end else begin
          ctl.op = OP_DEL;
        end
      end
      S_RD1: begin
        if (sts.range_err) begin
          ctl.res_set = 1'b1;
          ctl.res_status = ST_RANGE;
          state_next = S_OUT;
        end else begin
          ctl.op = OP_RD1;
          state_next = S_RD2;
        end
      end
      S_RD2: begin
        ctl.op = OP_RD2;
        state_next = S_RD3;
      end
      S_RD3: begin
        ctl.op = OP_RD3;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        state_next = S_OUT;
      end
      S_CLR: begin
        ctl.op = OP_CLEAR;
        ctl.res_set = 1'b1;
        ctl.res_status = ST_OK;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/amvt_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix vertex table datapath
// Label memory, adjacency row memory with row valid bits, scan and sweep logic.
// ----------------------------------------------------------------------------
module amvt_dpath #(
  parameter int MAX_VERTICES = amvt_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire amvt_pkg::ctl_t                ctl,
  output amvt_pkg::sts_t                     sts,
  input  wire logic [1:0]                    command,
  input  wire logic [amvt_pkg::LABEL_W-1:0]  label_a,
  input  wire logic [amvt_pkg::LABEL_W-1:0]  label_b,
  input  wire logic [amvt_pkg::INDEX_W-1:0]  row_index,
  input  wire logic [amvt_pkg::INDEX_W-1:0]  col_index,
  output logic [1:0]                         status,
  output logic [amvt_pkg::TOTAL_W-1:0]       vertex_total,
  output logic [amvt_pkg::LABEL_W-1:0]       row_label,
  output logic [amvt_pkg::LABEL_W-1:0]       col_label,
  output logic                               edge_bit
);
  import amvt_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [LABEL_W-1:0]      la_q, lb_q;
  logic [INDEX_W-1:0]      row_q, col_q;
  logic [CW-1:0]           count, idx;
  logic                    pend, zero_q;
  logic [AW-1:0]           cmp_idx, dst_q, pos;
  logic                    found_a, found_b;
  logic [AW-1:0]           slot_a, slot_b;

  logic [LABEL_W-1:0]      lab_mem [MAX_VERTICES];
  logic [LABEL_W-1:0]      lab_rd;
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd, adj_row, row_vld, removed;
  logic                    vld_rd;

  logic                    lab_re, adj_re, lab_we, adj_we;
  logic [AW-1:0]           lab_ra, adj_ra, lab_wa, adj_wa;
  logic [LABEL_W-1:0]      lab_wd;
  logic [MAX_VERTICES-1:0] adj_wd;

  logic [XW-1:0]           row_x, col_x, count_x;
  logic [CW-1:0]           src;
  logic                    src_ok, scan_issue, del_issue;
  logic [CW:0]             need;

  assign adj_row = vld_rd ? adj_rd : '0;
  assign row_x = XW'(row_q);
  assign col_x = XW'(col_q);
  assign count_x = XW'(count);
  assign src = (idx < CW'(pos)) ? idx : idx + 1'b1;
  assign src_ok = (src < CW'(MAX_VERTICES));
  assign scan_issue = (ctl.op == OP_SCAN) && (idx < count);
  assign del_issue = (ctl.op == OP_DEL) && (idx < count);
  assign need = (CW + 1)'(!found_a) + (CW + 1)'(!found_b && (la_q != lb_q));

  assign sts.scan_done = (idx == count) && !pend;
  assign sts.del_done = (idx == count) && !pend;
  assign sts.found_a = found_a;
  assign sts.full = ((CW + 1)'(count) + need) > (CW + 1)'(MAX_VERTICES);
  assign sts.range_err = (row_x >= count_x) || (col_x >= count_x);
  assign vertex_total = TOTAL_W'(count);

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (j < int'(pos)) begin
        removed[j] = adj_row[j];
      end else if (j + 1 < MAX_VERTICES) begin
        removed[j] = adj_row[j + 1];
      end else begin
        removed[j] = 1'b0;
      end
    end
  end

  always_comb begin
    lab_re = 1'b0;
    lab_ra = '0;
    adj_re = 1'b0;
    adj_ra = '0;
    lab_we = 1'b0;
    lab_wa = '0;
    lab_wd = '0;
    adj_we = 1'b0;
    adj_wa = '0;
    adj_wd = '0;
    unique case (ctl.op)
      OP_SCAN: begin
        lab_re = scan_issue;
        lab_ra = idx[AW-1:0];
      end
      OP_ADD_A: begin
        lab_we = !found_a;
        lab_wa = count[AW-1:0];
        lab_wd = la_q;
      end
      OP_ADD_B: begin
        lab_we = !found_b;
        lab_wa = count[AW-1:0];
        lab_wd = lb_q;
      end
      OP_RD_A: begin
        adj_re = 1'b1;
        adj_ra = slot_a;
      end
      OP_WR_A: begin
        adj_we = 1'b1;
        adj_wa = slot_a;
        adj_wd = adj_row | (MAX_VERTICES'(1) << slot_b);
      end
      OP_RD_B: begin
        adj_re = 1'b1;
        adj_ra = slot_b;
      end
      OP_WR_B: begin
        adj_we = 1'b1;
        adj_wa = slot_b;
        adj_wd = adj_row | (MAX_VERTICES'(1) << slot_a);
      end
      OP_DEL: begin
        lab_re = del_issue && src_ok;
        adj_re = del_issue && src_ok;
        lab_ra = src[AW-1:0];
        adj_ra = src[AW-1:0];
        lab_we = pend && !zero_q;
        lab_wa = dst_q;
        lab_wd = lab_rd;
        adj_we = pend;
        adj_wa = dst_q;
        adj_wd = zero_q ? '0 : removed;
      end
      OP_RD1: begin
        lab_re = 1'b1;
        adj_re = 1'b1;
        lab_ra = row_x[AW-1:0];
        adj_ra = row_x[AW-1:0];
      end
      OP_RD2: begin
        lab_re = 1'b1;
        lab_ra = col_x[AW-1:0];
      end
      default: begin
        lab_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    if (lab_re) begin
      lab_rd <= lab_mem[lab_ra];
    end
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd <= adj_mem[adj_ra];
      vld_rd <= row_vld[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      row_vld <= '0;
      pend <= 1'b0;
      idx <= '0;
    end else begin
      if (adj_we) begin
        row_vld[adj_wa] <= 1'b1;
      end
      unique case (ctl.op)
        OP_LOAD: begin
          idx <= '0;
          pend <= 1'b0;
        end
        OP_SCAN: begin
          pend <= scan_issue;
          if (scan_issue) begin
            idx <= idx + 1'b1;
          end
        end
        OP_ADD_A: begin
          if (!found_a) begin
            count <= count + 1'b1;
          end
        end
        OP_ADD_B: begin
          if (!found_b) begin
            count <= count + 1'b1;
          end
        end
        OP_DEL_INIT: begin
          idx <= '0;
          pend <= 1'b0;
        end
        OP_DEL: begin
          pend <= del_issue;
          if (del_issue) begin
            idx <= idx + 1'b1;
          end
        end
        OP_DEL_END: begin
          count <= count - 1'b1;
        end
        OP_CLEAR: begin
          count <= '0;
          row_vld <= '0;
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_set) begin
      status <= ctl.res_status;
    end
    unique case (ctl.op)
      OP_LOAD: begin
        la_q <= label_a;
        lb_q <= label_b;
        row_q <= row_index;
        col_q <= col_index;
        found_a <= 1'b0;
        found_b <= 1'b0;
        row_label <= '0;
        col_label <= '0;
        edge_bit <= 1'b0;
        if (command == CMD_CLEAR) begin
          slot_a <= '0;
        end
      end
      OP_SCAN: begin
        cmp_idx <= idx[AW-1:0];
        if (pend && !found_a && (lab_rd == la_q)) begin
          found_a <= 1'b1;
          slot_a <= cmp_idx;
        end
        if (pend && !found_b && (lab_rd == lb_q)) begin
          found_b <= 1'b1;
          slot_b <= cmp_idx;
        end
      end
      OP_ADD_A: begin
        if (!found_a) begin
          found_a <= 1'b1;
          slot_a <= count[AW-1:0];
          if (la_q == lb_q) begin
            found_b <= 1'b1;
            slot_b <= count[AW-1:0];
          end
        end
      end
      OP_ADD_B: begin
        if (!found_b) begin
          found_b <= 1'b1;
          slot_b <= count[AW-1:0];
        end
      end
      OP_DEL_INIT: begin
        pos <= slot_a;
      end
      OP_DEL: begin
        dst_q <= idx[AW-1:0];
        zero_q <= !src_ok;
      end
      OP_RD2: begin
        row_label <= lab_rd;
        edge_bit <= adj_row[col_x[AW-1:0]];
      end
      OP_RD3: begin
        col_label <= lab_rd;
      end
      default: begin
        cmp_idx <= cmp_idx;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/adjacency_matrix_vertex_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix vertex table core
// Undirected graph store: vertex label table plus bit adjacency matrix.
// ----------------------------------------------------------------------------
// Add edge and delete vertex first scan the label table; the label scan and
// the row sweep move through one memory entry per cycle.
// Throughput: one word at a time; the next word is taken after the result
// is accepted.
// Reset clears the vertex count and all row valid bits; no clearing pass.
module adjacency_matrix_vertex_table_core #(
  parameter int MAX_VERTICES = amvt_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    command,
  input  wire logic [amvt_pkg::LABEL_W-1:0]  label_a,
  input  wire logic [amvt_pkg::LABEL_W-1:0]  label_b,
  input  wire logic [amvt_pkg::INDEX_W-1:0]  row_index,
  input  wire logic [amvt_pkg::INDEX_W-1:0]  col_index,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [amvt_pkg::TOTAL_W-1:0]       vertex_total,
  output logic [amvt_pkg::LABEL_W-1:0]       row_label,
  output logic [amvt_pkg::LABEL_W-1:0]       col_label,
  output logic                               edge_bit
);
  import amvt_pkg::*;

  ctl_t ctl;
  sts_t sts;

  amvt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .ctl(ctl)
  );

  amvt_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .command(command),
    .label_a(label_a), .label_b(label_b), .row_index(row_index),
    .col_index(col_index), .status(status), .vertex_total(vertex_total),
    .row_label(row_label), .col_label(col_label), .edge_bit(edge_bit)
  );

endmodule
`default_nettype wire

@@ rtl/amvt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Adjacency matrix vertex table checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module amvt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [1:0]                    status,
  input wire logic [amvt_pkg::TOTAL_W-1:0]  vertex_total,
  input wire logic [amvt_pkg::LABEL_W-1:0]  row_label,
  input wire logic [amvt_pkg::LABEL_W-1:0]  col_label,
  input wire logic                          edge_bit
);
  import amvt_pkg::*;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("core not busy after taking a word");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE) |->
      (row_label == '0) && (col_label == '0) && !edge_bit)
    else $error("out of range read returned data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(vertex_total) && $stable(row_label) && $stable(col_label))
    else $error("result changed while stalled");

endmodule

bind adjacency_matrix_vertex_table_core amvt_checker u_amvt_checker (.*);
`default_nettype wire
